[rtl/crv_pkg.sv]
`default_nettype none

package crv_pkg;

  // Word format: signed Q3.13
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned ITERATIONS   = 32;
  localparam int unsigned GAIN_STEPS   = 4;
  localparam int unsigned PHASE_IDX_W  = 5;
  localparam int unsigned GAIN_SHIFT_W = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LAST_STAGE   = ITERATIONS + GAIN_STEPS;

  // pi and pi/2, truncated to the format
  localparam logic signed [DATA_W-1:0] PI_Q      = 16'sd25735;
  localparam logic signed [DATA_W-1:0] PI_HALF_Q = 16'sd12867;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_THIRD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FOURTH = 2'd3;

  localparam logic [GAIN_SHIFT_W-1:0] GAIN_FIRST_RST  = 4'd1;
  localparam logic [GAIN_SHIFT_W-1:0] GAIN_SECOND_RST = 4'd2;
  localparam logic [GAIN_SHIFT_W-1:0] GAIN_THIRD_RST  = 4'd5;
  localparam logic [GAIN_SHIFT_W-1:0] GAIN_FOURTH_RST = 4'd10;

  // Pre-rotation applied to an item; rotation mode only uses FOLD_PLUS
  typedef enum logic [1:0] {
    FOLD_NONE  = 2'd0,
    FOLD_PLUS  = 2'd1,
    FOLD_MINUS = 2'd2
  } crv_fold_e;

  typedef struct packed {
    logic                     rot;
    crv_fold_e                fold;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic signed [DATA_W-1:0] theta;
    logic signed [DATA_W-1:0] angle;
  } crv_stage_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first;
    logic signed [DATA_W-1:0] second;
    logic signed [DATA_W-1:0] angle;
  } crv_result_t;

  // atan(2^-k) truncated to the format
  function automatic logic signed [DATA_W-1:0] phase_of(input logic [PHASE_IDX_W-1:0] k);
    logic signed [DATA_W-1:0] ph;
    case (k)
      5'd0:    ph = 16'sd6433;
      5'd1:    ph = 16'sd3798;
      5'd2:    ph = 16'sd2006;
      5'd3:    ph = 16'sd1018;
      5'd4:    ph = 16'sd511;
      5'd5:    ph = 16'sd255;
      5'd6:    ph = 16'sd127;
      5'd7:    ph = 16'sd63;
      5'd8:    ph = 16'sd31;
      5'd9:    ph = 16'sd15;
      5'd10:   ph = 16'sd7;
      5'd11:   ph = 16'sd3;
      5'd12:   ph = 16'sd1;
      default: ph = 16'sd0;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

[rtl/crv_iter.sv]
`default_nettype none

module crv_iter (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    en_i,
  input  wire logic [crv_pkg::PHASE_IDX_W-1:0]         shift_i,
  input  wire logic signed [crv_pkg::DATA_W-1:0]       phase_i,
  input  wire logic                                    valid_i,
  input  wire crv_pkg::crv_stage_t                     stage_i,
  output logic                                         valid_o,
  output crv_pkg::crv_stage_t                          stage_o
);

  logic                            valid_q;
  crv_pkg::crv_stage_t             stage_q;
  crv_pkg::crv_stage_t             stage_d;
  logic signed [crv_pkg::DATA_W-1:0] dx;
  logic signed [crv_pkg::DATA_W-1:0] dy;
  logic                            up;

  always_comb begin
    dx      = stage_i.cy >>> shift_i;
    dy      = stage_i.cx >>> shift_i;
    // turn counterclockwise while behind the target angle, or while y is negative
    up      = stage_i.rot ? ($signed(stage_i.theta) < $signed(stage_i.angle))
                          : stage_i.cy[crv_pkg::DATA_W-1];
    stage_d = stage_i;
    if (up) begin
      stage_d.cx    = stage_i.cx - dx;
      stage_d.cy    = stage_i.cy + dy;
      stage_d.theta = stage_i.theta + phase_i;
    end else begin
      stage_d.cx    = stage_i.cx + dx;
      stage_d.cy    = stage_i.cy - dy;
      stage_d.theta = stage_i.theta - phase_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

[rtl/crv_gain.sv]
`default_nettype none

module crv_gain (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                sub_i,
  input  wire logic [crv_pkg::GAIN_SHIFT_W-1:0]    shift_i,
  input  wire logic                                valid_i,
  input  wire crv_pkg::crv_stage_t                 stage_i,
  output logic                                     valid_o,
  output crv_pkg::crv_stage_t                      stage_o
);

  logic                              valid_q;
  crv_pkg::crv_stage_t               stage_q;
  crv_pkg::crv_stage_t               stage_d;
  logic signed [crv_pkg::DATA_W-1:0] dx;
  logic signed [crv_pkg::DATA_W-1:0] dy;

  always_comb begin
    dx       = stage_i.cx >>> shift_i;
    dy       = stage_i.cy >>> shift_i;
    stage_d  = stage_i;
    stage_d.cx = sub_i ? (stage_i.cx - dx) : (stage_i.cx + dx);
    // vectoring keeps adding on y
    stage_d.cy = (sub_i && stage_i.rot) ? (stage_i.cy - dy) : (stage_i.cy + dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

[rtl/cordic_rotate_vector_unit.sv]
`default_nettype none

// CORDIC rotation / vectoring unit, signed Q3.13, one item per cycle unless stalled.
// Pipeline: 1 fold stage, 32 iteration stages, 4 gain stages, output register.
// Throughput: one item per cycle while the skid entry is empty; a two-entry output
// buffer (result register plus skid) registers the downstream stall, so the
// pipeline stalls only once a result has parked in the skid. Reset clears all valid
// bits and loads the gain shifts with 1, 2, 5, 10.

module cordic_rotate_vector_unit (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // configuration write port
  input  wire logic                                    cfg_we_i,
  input  wire logic [crv_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [crv_pkg::GAIN_SHIFT_W-1:0]        cfg_data_i,
  // input items
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic                                    operation_i,
  input  wire logic signed [crv_pkg::DATA_W-1:0]       x_in_i,
  input  wire logic signed [crv_pkg::DATA_W-1:0]       y_in_i,
  input  wire logic signed [crv_pkg::DATA_W-1:0]       angle_in_i,
  // result items
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed [crv_pkg::DATA_W-1:0]            out_first_o,
  output logic signed [crv_pkg::DATA_W-1:0]            out_second_o,
  output logic signed [crv_pkg::DATA_W-1:0]            out_angle_o
);

  // ---------------------------------------------------------------------------
  // Gain shift registers
  // ---------------------------------------------------------------------------
  logic [crv_pkg::GAIN_SHIFT_W-1:0] gain_shift_q [crv_pkg::GAIN_STEPS];
  logic [crv_pkg::GAIN_SHIFT_W-1:0] gain_shift_d [crv_pkg::GAIN_STEPS];

  always_comb begin
    gain_shift_d = gain_shift_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        crv_pkg::REG_GAIN_FIRST:  gain_shift_d[0] = cfg_data_i;
        crv_pkg::REG_GAIN_SECOND: gain_shift_d[1] = cfg_data_i;
        crv_pkg::REG_GAIN_THIRD:  gain_shift_d[2] = cfg_data_i;
        crv_pkg::REG_GAIN_FOURTH: gain_shift_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_shift_q[0] <= crv_pkg::GAIN_FIRST_RST;
      gain_shift_q[1] <= crv_pkg::GAIN_SECOND_RST;
      gain_shift_q[2] <= crv_pkg::GAIN_THIRD_RST;
      gain_shift_q[3] <= crv_pkg::GAIN_FOURTH_RST;
    end else begin
      gain_shift_q <= gain_shift_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipeline advances unless the skid entry is
  // occupied. The skid is registered, so in_stall_o carries no path from
  // out_stall_i.
  // ---------------------------------------------------------------------------
  logic        skid_valid_q;
  logic        skid_valid_d;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        adv;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // stage 0 is the fold stage; stages 1..ITERATIONS the rotations; the rest gain
  logic                valid_s [crv_pkg::LAST_STAGE+1];
  crv_pkg::crv_stage_t stage_s [crv_pkg::LAST_STAGE+1];

  // ---------------------------------------------------------------------------
  // Fold stage: bring the angle into [-pi/2, pi/2] or the vector into the
  // right half plane.
  // ---------------------------------------------------------------------------
  logic                valid0_q;
  crv_pkg::crv_stage_t stage0_q;
  crv_pkg::crv_stage_t stage0_d;

  always_comb begin
    stage0_d.rot   = operation_i;
    stage0_d.fold  = crv_pkg::FOLD_NONE;
    stage0_d.cx    = x_in_i;
    stage0_d.cy    = y_in_i;
    stage0_d.theta = '0;
    stage0_d.angle = angle_in_i;
    if (operation_i) begin
      if ($signed(angle_in_i) < -crv_pkg::PI_HALF_Q) begin
        stage0_d.angle = angle_in_i + crv_pkg::PI_Q;
        stage0_d.fold  = crv_pkg::FOLD_PLUS;
      end else if ($signed(angle_in_i) > crv_pkg::PI_HALF_Q) begin
        stage0_d.angle = angle_in_i - crv_pkg::PI_Q;
        stage0_d.fold  = crv_pkg::FOLD_PLUS;
      end
    end else if (x_in_i[crv_pkg::DATA_W-1]) begin
      // quadrant II: turn by -pi/2; quadrant III: turn by +pi/2
      if (!y_in_i[crv_pkg::DATA_W-1]) begin
        stage0_d.cx   = y_in_i;
        stage0_d.cy   = -x_in_i;
        stage0_d.fold = crv_pkg::FOLD_PLUS;
      end else begin
        stage0_d.cx   = -y_in_i;
        stage0_d.cy   = x_in_i;
        stage0_d.fold = crv_pkg::FOLD_MINUS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (adv) begin
      valid0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage0_q <= stage0_d;
    end
  end

  assign valid_s[0] = valid0_q;
  assign stage_s[0] = stage0_q;

  // ---------------------------------------------------------------------------
  // Rotation stages, one shift-add iteration each
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < crv_pkg::ITERATIONS; k++) begin : g_iter
    crv_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .shift_i (crv_pkg::PHASE_IDX_W'(k)),
      .phase_i (crv_pkg::phase_of(crv_pkg::PHASE_IDX_W'(k))),
      .valid_i (valid_s[k]),
      .stage_i (stage_s[k]),
      .valid_o (valid_s[k+1]),
      .stage_o (stage_s[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Gain correction stages, signs alternate starting with subtract
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < crv_pkg::GAIN_STEPS; g++) begin : g_gain
    crv_gain u_gain (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .sub_i   ((g % 2) == 0),
      .shift_i (gain_shift_q[g]),
      .valid_i (valid_s[crv_pkg::ITERATIONS+g]),
      .stage_i (stage_s[crv_pkg::ITERATIONS+g]),
      .valid_o (valid_s[crv_pkg::ITERATIONS+g+1]),
      .stage_o (stage_s[crv_pkg::ITERATIONS+g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Result formatting: undo the fold in rotation mode, negate and adjust the
  // accumulated angle in vectoring mode.
  // ---------------------------------------------------------------------------
  crv_pkg::crv_stage_t last;
  logic                last_valid;
  crv_pkg::crv_result_t post;

  assign last       = stage_s[crv_pkg::LAST_STAGE];
  assign last_valid = valid_s[crv_pkg::LAST_STAGE];

  always_comb begin
    if (last.rot) begin
      post.first  = (last.fold != crv_pkg::FOLD_NONE) ? -last.cx : last.cx;
      post.second = (last.fold != crv_pkg::FOLD_NONE) ? -last.cy : last.cy;
      post.angle  = '0;
    end else begin
      post.first  = last.cx;
      post.second = '0;
      case (last.fold)
        crv_pkg::FOLD_PLUS:  post.angle = crv_pkg::PI_HALF_Q - last.theta;
        crv_pkg::FOLD_MINUS: post.angle = -last.theta - crv_pkg::PI_HALF_Q;
        default:             post.angle = -last.theta;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: result register plus one skid entry. A result that arrives
  // while the register is stalled parks in the skid, which then holds the
  // pipeline until the register drains.
  // ---------------------------------------------------------------------------
  crv_pkg::crv_result_t out_q;
  crv_pkg::crv_result_t out_d;
  crv_pkg::crv_result_t skid_q;
  crv_pkg::crv_result_t skid_d;
  logic                 out_held;

  assign out_held = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (adv) begin
      if (out_held) begin
        // park the arriving item
        skid_valid_d = last_valid;
        skid_d       = post;
      end else begin
        out_valid_d = last_valid;
        out_d       = post;
      end
    end else if (!out_stall_i) begin
      // drain the skid into the result register
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_q.first;
  assign out_second_o = out_q.second;
  assign out_angle_o  = out_q.angle;

endmodule

`default_nettype wire
